>>> src/jls_pkg.sv
package jls_pkg;

  localparam int MAX_COLS    = 1024;
  localparam int STORE_DEPTH = MAX_COLS + 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(STORE_DEPTH + 1);

  localparam int SAMPLE_W    = 23;
  localparam int CFG_COLS_W  = 11;
  localparam int CFG_ROWS_W  = 16;
  localparam int CFG_SWEEP_W = 16;
  localparam int ROW_W       = CFG_ROWS_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 23;

  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS      = 2'd0,
    CFG_ROWS      = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_MAX_SWEEP = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_COLS_W-1:0]  cols_in_use;
    logic [CFG_ROWS_W-1:0]  rows_in_use;
    sample_t                error_threshold;
    logic [CFG_SWEEP_W-1:0] max_sweeps;
  } cfg_t;

  typedef struct packed {
    sample_t two_above;
    sample_t above;
  } line_word_t;

  typedef struct packed {
    sample_t nv;
    sample_t centre;
    logic    last;
  } q_entry_t;

endpackage

>>> src/jls_queue.sv
module jls_queue
  import jls_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  q_entry_t          push_data,
  input  logic              pop,
  output q_entry_t          pop_data,
  output logic              not_empty,
  output logic [QCNT_W-1:0] count
);

  q_entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;

  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> src/jls_front.sv
module jls_front
  import jls_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  sample_t           old_sample,
  input  logic [QCNT_W-1:0] q_count,
  output logic              push,
  output q_entry_t          push_data
);

  line_word_t          mem [STORE_DEPTH];

  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [COL_W-1:0]    fill;

  logic [COL_W-1:0]    cols_eff;
  logic [COL_W-1:0]    cols_lim;
  logic [ROW_W-1:0]    rows_eff;
  logic [ROW_W-1:0]    rows_lim;
  logic [COL_W-1:0]    col0;
  logic [ROW_W-1:0]    row0;
  logic [COL_W-1:0]    col1;
  logic [COL_W-1:0]    column_count_next;
  logic [ROW_W-1:0]    row_count_next;
  logic                interior;
  logic                last;
  logic [ADDR_W-1:0]   addr_a;
  logic [ADDR_W-1:0]   addr_b;
  logic                accept;

  logic                s1_valid;
  sample_t             s1_sample;
  logic [ADDR_W-1:0]   s1_col;
  logic                s1_interior;
  logic                s1_last;
  line_word_t          rd_a;
  line_word_t          rd_b;
  logic                va;
  logic                vb;
  logic                byp_a;
  logic                byp_b;
  line_word_t          byp_word;
  sample_t             prev_centre;

  line_word_t          word_a;
  line_word_t          word_b;
  line_word_t          wr_word;
  logic [SAMPLE_W+1:0] sum;

  assign in_stall = (QCNT_W'(q_count) + QCNT_W'(s1_valid)) >= QCNT_W'(QDEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (cfg.cols_in_use == '0) begin
      cols_eff = COL_W'(1);
    end else if (int'(cfg.cols_in_use) > MAX_COLS) begin
      cols_eff = COL_W'(MAX_COLS);
    end else begin
      cols_eff = COL_W'(cfg.cols_in_use);
    end
    cols_lim = cols_eff + COL_W'(1);
    rows_eff = (cfg.rows_in_use == '0) ? ROW_W'(1) : ROW_W'(cfg.rows_in_use);
    rows_lim = rows_eff + ROW_W'(1);

    col0 = column_count;
    row0 = row_count;
    if (col0 > cols_lim || int'(col0) >= STORE_DEPTH) begin
      col0 = '0;
      row0 = row0 + ROW_W'(1);
    end
    if (row0 > rows_lim) begin
      row0 = '0;
    end

    interior = (row0 >= ROW_W'(2)) && (col0 >= COL_W'(1)) && (col0 <= cols_eff);
    last     = (row0 == rows_lim) && (col0 == cols_eff);

    col1 = col0 + COL_W'(1);
    if (col1 > cols_lim) begin
      column_count_next = '0;
      row_count_next    = row0 + ROW_W'(1);
      if (row_count_next > rows_lim) begin
        row_count_next = '0;
      end
    end else begin
      column_count_next = col1;
      row_count_next    = row0;
    end

    addr_a = ADDR_W'(col0);
    addr_b = (int'(col0) >= STORE_DEPTH - 1) ? '0 : ADDR_W'(col1);
  end

  always_comb begin
    word_a  = byp_a ? byp_word : (va ? rd_a : '0);
    word_b  = byp_b ? byp_word : (vb ? rd_b : '0);
    wr_word = '{two_above: word_a.above, above: s1_sample};
    sum     = (SAMPLE_W+2)'(word_a.two_above) + (SAMPLE_W+2)'(prev_centre)
            + (SAMPLE_W+2)'(word_b.above) + (SAMPLE_W+2)'(s1_sample);
  end

  assign push             = s1_valid && s1_interior;
  assign push_data.nv     = sum[SAMPLE_W+1:2];
  assign push_data.centre = word_a.above;
  assign push_data.last   = s1_last;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
    if (s1_valid) begin
      mem[s1_col] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample   <= old_sample;
      s1_col      <= addr_a;
      s1_interior <= interior;
      s1_last     <= last;
      va          <= (COL_W'(addr_a) < fill);
      vb          <= (COL_W'(addr_b) < fill);
      byp_a       <= s1_valid && (addr_a == s1_col);
      byp_b       <= s1_valid && (addr_b == s1_col);
      byp_word    <= wr_word;
    end
    if (s1_valid) begin
      prev_centre <= word_a.above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
      fill         <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      if (s1_valid && COL_W'(s1_col) >= fill) begin
        fill <= COL_W'(s1_col) + COL_W'(1);
      end
    end
  end

endmodule

>>> src/jls_back.sv
module jls_back
  import jls_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     q_not_empty,
  input  q_entry_t q_data,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output sample_t  new_value,
  output sample_t  max_change,
  output logic     sweep_end,
  output logic     converged,
  output logic     limit_reached
);

  sample_t                running_max;
  logic [CFG_SWEEP_W-1:0] sweep_count;

  sample_t                change;
  sample_t                max_next;
  logic [CFG_SWEEP_W-1:0] sweep_count_next;

  assign pop = q_not_empty && (!out_valid || !out_stall);

  always_comb begin
    change   = (q_data.nv >= q_data.centre) ? (q_data.nv - q_data.centre)
                                            : (q_data.centre - q_data.nv);
    max_next = (change > running_max) ? change : running_max;
    sweep_count_next = (sweep_count == '1) ? sweep_count
                                           : sweep_count + CFG_SWEEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      new_value     <= q_data.nv;
      max_change    <= max_next;
      sweep_end     <= q_data.last;
      converged     <= q_data.last && (max_next <= cfg.error_threshold);
      limit_reached <= q_data.last && (sweep_count_next >= cfg.max_sweeps);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      running_max <= '0;
      sweep_count <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (q_data.last) begin
          running_max <= '0;
          sweep_count <= sweep_count_next;
        end else begin
          running_max <= max_next;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/jacobi_laplace_sweep_core.sv
// Streaming Jacobi sweep over a 2D Laplace grid, five-point stencil.
// Input channel (in_valid/in_stall/old_sample): the previous iterate in raster
// order, boundary cells included, (rows+2) x (cols+2) cells, unsigned Q7.16.
// A transaction moves on a clock edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall/...): one transaction per interior
// point, produced when the cell below it arrives; sweep_end marks the last
// point of a sweep and qualifies converged and limit_reached.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while the block is idle.
// Throughput: one cell per cycle while in_stall is low. The line-store
// memory is read at the cell column and the next column on accept and is
// written in the next cycle. Results pass the queue and an output register.
// A four-entry queue sits between the stencil front end and the output stage;
// when out_stall is held, results back up into the queue and in_stall rises
// once the queued results plus the cell in flight reach four.
// Reset (rst, synchronous): position, sweep count and running max clear,
// config returns to defaults, and the line stores read as zero until written
// through a fill mark, so no clearing pass is needed.
module jacobi_laplace_sweep_core
  import jls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sample_t               old_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sample_t               new_value,
  output sample_t               max_change,
  output logic                  sweep_end,
  output logic                  converged,
  output logic                  limit_reached,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic              push;
  q_entry_t          push_data;
  logic              pop;
  q_entry_t          pop_data;
  logic              q_not_empty;
  logic [QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols_in_use     <= CFG_COLS_W'(1024);
      cfg.rows_in_use     <= CFG_ROWS_W'(1024);
      cfg.error_threshold <= SAMPLE_W'(655);
      cfg.max_sweeps      <= CFG_SWEEP_W'(4000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_COLS:      cfg.cols_in_use     <= cfg_data[CFG_COLS_W-1:0];
        CFG_ROWS:      cfg.rows_in_use     <= cfg_data[CFG_ROWS_W-1:0];
        CFG_THRESHOLD: cfg.error_threshold <= cfg_data[SAMPLE_W-1:0];
        CFG_MAX_SWEEP: cfg.max_sweeps      <= cfg_data[CFG_SWEEP_W-1:0];
        default: ;
      endcase
    end
  end

  jls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .old_sample (old_sample),
    .q_count    (q_count),
    .push       (push),
    .push_data  (push_data)
  );

  jls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  jls_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_not_empty   (q_not_empty),
    .q_data        (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .new_value     (new_value),
    .max_change    (max_change),
    .sweep_end     (sweep_end),
    .converged     (converged),
    .limit_reached (limit_reached)
  );

endmodule

>>> src/jls_checker.sv
module jls_checker
  import jls_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input sample_t               new_value,
  input sample_t               max_change,
  input logic                  sweep_end,
  input logic                  converged,
  input logic                  limit_reached
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_value) && $stable(max_change)
      && $stable(sweep_end))
    else $error("output transaction changed while stalled");

  // sweep flags only on the last point
  a_flags_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sweep_end |-> !converged && !limit_reached)
    else $error("sweep flags outside sweep end");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind jacobi_laplace_sweep_core jls_checker u_jls_checker (.*);

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jls_pkg::*;

  localparam int GAP_PERCENT   = 23;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_CELLS  = 200;
  localparam int MAX_REPORTS   = 40;
  localparam int unsigned FULL_SCALE = 6553600;

  typedef struct packed {
    sample_t new_value;
    sample_t max_change;
    logic    sweep_end;
    logic    converged;
    logic    limit_reached;
  } point_t;

  typedef enum {FILL_NOISE, FILL_RANGE, FILL_FLAT, FILL_SMOOTH, FILL_RAILS} fill_t;

  // Five-point stencil tracker: mirrors the line stores and sweep bookkeeping.
  class sweep_checker;
    cfg_t        regs;
    sample_t     two_up [STORE_DEPTH];
    sample_t     one_up [STORE_DEPTH];
    int unsigned col_pos, row_pos;
    sample_t     peak_change;
    int unsigned sweeps_done;
    point_t      pending [$];
    int unsigned errors;

    function new();
      regs.cols_in_use     = 11'd1024;
      regs.rows_in_use     = 16'd1024;
      regs.error_threshold = 23'd655;
      regs.max_sweeps      = 16'd4000;
      foreach (two_up[i]) begin
        two_up[i] = '0;
        one_up[i] = '0;
      end
      col_pos = 0;
      row_pos = 0;
      peak_change = '0;
      sweeps_done = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_COLS:      regs.cols_in_use = data[CFG_COLS_W-1:0];
        CFG_ROWS:      regs.rows_in_use = data[CFG_ROWS_W-1:0];
        CFG_THRESHOLD: regs.error_threshold = data;
        CFG_MAX_SWEEP: regs.max_sweeps = data[CFG_SWEEP_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned width_now();
      if (regs.cols_in_use == 0) return 1;
      if (regs.cols_in_use > MAX_COLS) return MAX_COLS;
      return regs.cols_in_use;
    endfunction

    function int unsigned height_now();
      return (regs.rows_in_use == 0) ? 1 : regs.rows_in_use;
    endfunction

    function void take_cell(sample_t s);
      int unsigned cols, rows, c, r, total;
      sample_t nv, centre, change;
      point_t p;
      cols = width_now();
      rows = height_now();
      // stale position after a geometry change
      if (col_pos > cols + 1 || col_pos >= STORE_DEPTH) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos > rows + 1) row_pos = 0;
      c = col_pos;
      r = row_pos;
      if (r >= 2 && c >= 1 && c <= cols) begin
        total = two_up[c] + two_up[c-1] + one_up[c+1] + s;
        nv = sample_t'(total >> 2);
        centre = one_up[c];
        change = (nv >= centre) ? nv - centre : centre - nv;
        if (change > peak_change) peak_change = change;
        p.new_value = nv;
        p.max_change = peak_change;
        p.sweep_end = (r == rows + 1) && (c == cols);
        p.converged = 1'b0;
        p.limit_reached = 1'b0;
        if (p.sweep_end) begin
          if (sweeps_done < 65535) sweeps_done++;
          p.converged = (peak_change <= regs.error_threshold);
          p.limit_reached = (sweeps_done >= regs.max_sweeps);
          peak_change = '0;
        end
        pending.push_back(p);
      end
      two_up[c] = one_up[c];
      one_up[c] = s;
      col_pos = c + 1;
      if (col_pos > cols + 1) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos > rows + 1) row_pos = 0;
      end
    endfunction

    function void compare(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, got new_value %0d",
                   $time, got.new_value);
        return;
      end
      want = pending.pop_front();
      compare("new_value", want.new_value, got.new_value);
      compare("max_change", want.max_change, got.max_change);
      compare("sweep_end", want.sweep_end, got.sweep_end);
      compare("converged", want.converged, got.converged);
      compare("limit_reached", want.limit_reached, got.limit_reached);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sample_t               old_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sample_t               new_value;
  sample_t               max_change;
  logic                  sweep_end;
  logic                  converged;
  logic                  limit_reached;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int unsigned quiet = 0;

  sweep_checker sb = new();

  jacobi_laplace_sweep_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .old_sample    (old_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .new_value     (new_value),
    .max_change    (max_change),
    .sweep_end     (sweep_end),
    .converged     (converged),
    .limit_reached (limit_reached),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < GAP_PERCENT);
  endfunction

  // receiver: random stalls plus one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = take_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_point(point_t'{new_value, max_change, sweep_end, converged, limit_reached});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_cell(sample_t s);
    while (take_gap()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    old_sample = s;
    do @(posedge clk); while (in_stall);
    sb.take_cell(s);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, int unsigned data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, cfg_data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // cells that make no result may still be in flight when the queue empties
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic sample_t pick_sample(fill_t fill, sample_t base);
    case (fill)
      FILL_NOISE:  return sample_t'($urandom());
      FILL_RANGE:  return sample_t'($urandom_range(0, FULL_SCALE));
      FILL_FLAT:   return base;
      FILL_SMOOTH: return sample_t'(base + $urandom_range(0, 40));
      default:     return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  task automatic send_block(int unsigned n, fill_t fill, sample_t base);
    repeat (n) send_cell(pick_sample(fill, base));
  endtask

  task automatic random_config();
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_COLS, ($urandom_range(0, 9) == 0) ? $urandom_range(1024, 2047)
                                                       : $urandom_range(0, 8));
    if ($urandom_range(0, 1) != 0)
      write_reg(CFG_ROWS, ($urandom_range(0, 11) == 0) ? 65535 : $urandom_range(0, 5));
    if ($urandom_range(0, 1) != 0)
      case ($urandom_range(0, 3))
        0: write_reg(CFG_THRESHOLD, 0);
        1: write_reg(CFG_THRESHOLD, $urandom_range(0, 3000));
        2: write_reg(CFG_THRESHOLD, FULL_SCALE);
        default: write_reg(CFG_THRESHOLD, $urandom_range(0, 8388607));
      endcase
    if ($urandom_range(0, 1) != 0)
      case ($urandom_range(0, 3))
        0: write_reg(CFG_MAX_SWEEP, 0);
        1: write_reg(CFG_MAX_SWEEP, 65535);
        2: write_reg(CFG_MAX_SWEEP, sb.sweeps_done + $urandom_range(0, 3));
        default: write_reg(CFG_MAX_SWEEP, $urandom_range(1, 65535));
      endcase
  endtask

  initial begin
    int unsigned random_cells, n, grid;
    fill_t fill;
    sample_t base;
    random_cells = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // out-of-range geometry, zero threshold, zero sweep limit, rail values
    write_reg(CFG_COLS, 0);
    write_reg(CFG_ROWS, 0);
    write_reg(CFG_THRESHOLD, 0);
    write_reg(CFG_MAX_SWEEP, 0);
    send_cell('0);
    send_cell('1);
    send_cell(sample_t'(FULL_SCALE));
    send_cell(23'h555555);
    send_cell(23'h2AAAAA);
    send_cell('1);
    send_cell('1);
    send_cell('1);
    send_cell('0);
    drain();

    // flat grid converges; limit not yet reached
    write_reg(CFG_COLS, 2);
    write_reg(CFG_ROWS, 1);
    write_reg(CFG_THRESHOLD, 8388607);
    write_reg(CFG_MAX_SWEEP, 3);
    send_block(12, FILL_FLAT, sample_t'(1234567));
    drain();

    // several sweeps back to back, no gaps on either side
    steady = 1'b1;
    write_reg(CFG_COLS, 6);
    write_reg(CFG_ROWS, 3);
    write_reg(CFG_THRESHOLD, $urandom_range(0, 60));
    write_reg(CFG_MAX_SWEEP, 65535);
    send_block(3 * 8 * 5, FILL_SMOOTH, sample_t'($urandom_range(0, FULL_SCALE - 64)));
    drain();
    steady = 1'b0;

    // output held off while cells keep coming, so the input backs up
    write_reg(CFG_COLS, 3);
    write_reg(CFG_ROWS, 6);
    hold_req = 1'b1;
    send_block(60, FILL_RANGE, '0);
    drain();

    while (random_cells < RANDOM_CELLS) begin
      random_config();
      grid = (sb.width_now() + 2) * (sb.height_now() + 2);
      n = (grid <= 120) ? $urandom_range(grid / 2, 2 * grid) : $urandom_range(5, 40);
      fill = fill_t'($urandom_range(0, 4));
      base = sample_t'($urandom_range(0, FULL_SCALE - 64));
      send_block(n, fill, base);
      random_cells += n;
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
